[hdl/nyutc_pkg.sv]
`default_nettype none
package nyutc_pkg;

    localparam int YearW   = 14;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;
    localparam int StatusW = 2;
    localparam int UtcW    = 39;

    // register stages of the conversion pipeline
    localparam int NumStages = 7;

    typedef enum logic [StatusW-1:0] {
        StatusOk    = 2'd0,
        StatusRange = 2'd1,
        StatusDst   = 2'd2
    } status_t;

    localparam logic [YearW-1:0]   YearMin    = 14'd1900;
    localparam logic [YearW-1:0]   YearMax    = 14'd9999;
    localparam logic [MonthW-1:0]  MonthJan   = 4'd1;
    localparam logic [MonthW-1:0]  MonthFeb   = 4'd2;
    localparam logic [MonthW-1:0]  MonthMar   = 4'd3;
    localparam logic [MonthW-1:0]  MonthNov   = 4'd11;
    localparam logic [MonthW-1:0]  MonthDec   = 4'd12;
    localparam logic [HourW-1:0]   HourMax    = 5'd23;
    localparam logic [HourW-1:0]   HourRepeat = 5'd1;
    localparam logic [HourW-1:0]   HourGap    = 5'd2;
    localparam logic [HourW-1:0]   HourDstOn  = 5'd3;
    localparam logic [MinuteW-1:0] MinuteMax  = 6'd59;
    localparam logic [SecondW-1:0] SecondMax  = 6'd59;

    // floor(x / 100) = (x * 5243) >> 19, exact for any 14-bit x
    localparam logic [12:0] Div100Mul   = 13'd5243;
    localparam int          Div100Shift = 19;

    localparam logic [16:0] DstOffset = 17'd14400;
    localparam logic [16:0] StdOffset = 17'd18000;
    localparam logic [16:0] SecPerDay = 17'd86400;
    // day number of 1970-01-01 counted from 0000-03-01
    localparam logic signed [22:0] EpochDay = 23'sd719468;
    // 0000-03-01 is a wednesday: weekday = (n + 3) mod 7, 0 = sunday
    localparam logic [21:0] WeekdayBias = 22'd3;

    localparam logic signed [UtcW-1:0] UtcMin = -39'sd2208970800;
    localparam logic signed [UtcW-1:0] UtcMax = 39'sd253402318799;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
        logic [DayW-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // days from march 1 to the first of the month, march-based month index
    function automatic logic [8:0] march_offset(input logic [MonthW-1:0] mp);
        logic [8:0] ofs;
        case (mp)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

    // 8 = 1 mod 7, so octal digits fold
    function automatic logic [2:0] mod7(input logic [21:0] v);
        logic [5:0] f1;
        logic [3:0] f2;
        logic [3:0] f3;
        f1 = {5'b0, v[21]};
        for (int i = 0; i < 7; i++)
        begin
            f1 = f1 + {3'b0, v[3*i +: 3]};
        end
        f2 = {1'b0, f1[5:3]} + {1'b0, f1[2:0]};
        f3 = {3'b0, f2[3]} + {1'b0, f2[2:0]};
        return (f3 == 4'd7) ? 3'd0 : f3[2:0];
    endfunction

endpackage
`default_nettype wire

[hdl/nyutc_in_if.sv]
`default_nettype none
interface nyutc_in_if;
    logic                             valid;
    logic                             ready;
    logic [nyutc_pkg::YearW-1:0]      year;
    logic [nyutc_pkg::MonthW-1:0]     month;
    logic [nyutc_pkg::DayW-1:0]       day;
    logic [nyutc_pkg::HourW-1:0]      hour;
    logic [nyutc_pkg::MinuteW-1:0]    minute;
    logic [nyutc_pkg::SecondW-1:0]    second;

    modport source (output valid, year, month, day, hour, minute, second, input ready);
    modport sink   (input valid, year, month, day, hour, minute, second, output ready);
endinterface
`default_nettype wire

[hdl/nyutc_out_if.sv]
`default_nettype none
interface nyutc_out_if;
    logic                                valid;
    logic                                ready;
    logic [nyutc_pkg::StatusW-1:0]       status;
    logic signed [nyutc_pkg::UtcW-1:0]   utc_seconds;

    modport source (output valid, status, utc_seconds, input ready);
    modport sink   (input valid, status, utc_seconds, output ready);
endinterface
`default_nettype wire

[hdl/new_york_civil_time_to_utc.sv]
`default_nettype none
// New York civil date and time to UTC Unix seconds. Each item on civil carries year, month,
// day, hour, minute and second; each gives exactly one item on utc, in order. status is ok,
// range (a field outside its valid span: year 1900..9999, month 1..12, day within the
// gregorian month, hour 0..23, minute and second 0..59) or dst (hour 2 on the second sunday
// of march, which does not exist, or hour 1 on the first sunday of november, which occurs
// twice). utc_seconds is civil time plus 4 h under daylight saving time and plus 5 h
// otherwise, and zero whenever status is not ok. The block is a seven-stage pipeline that
// takes one item every cycle while utc.ready is high; an item passes through stage registers
// s1 to s7, shows on utc from s7 and leaves when utc.ready is high. The per-stage ready chain
// lets any empty stage fill while the output stalls, so civil.ready is always high while
// utc.valid is low. Two divide-by-100 multipliers and the day-times-86400 multiplier each
// sit in a stage of their own.
module new_york_civil_time_to_utc (
    input  wire logic       clk,
    input  wire logic       rst_n,
    nyutc_in_if.sink        civil,
    nyutc_out_if.source     utc
);

    // stage 1: fields, march-based year, year / 100, coarse range check
    typedef struct packed {
        logic [13:0] year;
        logic [13:0] yy;
        logic [7:0]  cy;
        logic [3:0]  month;
        logic [3:0]  mp;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        ok;
    } s1_t;

    // stage 2: century of march year, day check, seconds of day
    typedef struct packed {
        logic [13:0] yy;
        logic [7:0]  c;
        logic [3:0]  mp;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [16:0] hms;
        logic        ok;
    } s2_t;

    // stage 3: day number of the first of the month
    typedef struct packed {
        logic [21:0] nbase;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [16:0] hms;
        logic        ok;
    } s3_t;

    // stage 4: weekday of the first, day number of the date
    typedef struct packed {
        logic [2:0]  wday;
        logic [21:0] n;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [16:0] hms;
        logic        ok;
    } s4_t;

    // stage 5: dst decision, days since epoch
    typedef struct packed {
        logic signed [22:0]  days;
        logic [16:0]         sod;
        nyutc_pkg::status_t  status;
    } s5_t;

    // stage 6: day product
    typedef struct packed {
        logic [38:0]         prod;
        logic [16:0]         sod;
        nyutc_pkg::status_t  status;
    } s6_t;

    // stage 7: output register
    typedef struct packed {
        logic signed [38:0]  utc;
        nyutc_pkg::status_t  status;
    } s7_t;

    logic [nyutc_pkg::NumStages-1:0] valid_reg;
    logic [nyutc_pkg::NumStages-1:0] valid_next;
    logic [nyutc_pkg::NumStages-1:0] adv;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;
    s7_t s7_reg, s7_next;

    // a stage loads when it is empty or the one after it loads too
    always_comb
    begin
        adv[nyutc_pkg::NumStages-1] = !valid_reg[nyutc_pkg::NumStages-1] || utc.ready;
        for (int k = nyutc_pkg::NumStages - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? civil.valid : valid_reg[0];
        for (int k = 1; k < nyutc_pkg::NumStages; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign civil.ready     = adv[0];
    assign utc.valid       = valid_reg[nyutc_pkg::NumStages-1];
    assign utc.status      = s7_reg.status;
    assign utc.utc_seconds = s7_reg.utc;

    // stage 1
    logic [26:0] cy_prod;
    always_comb
    begin
        s1_next.year   = civil.year;
        s1_next.month  = civil.month;
        s1_next.day    = civil.day;
        s1_next.hour   = civil.hour;
        s1_next.minute = civil.minute;
        s1_next.second = civil.second;
        // january and february belong to the previous march-based year
        s1_next.yy = (civil.month <= nyutc_pkg::MonthFeb) ? civil.year - 14'd1 : civil.year;
        s1_next.mp = (civil.month > nyutc_pkg::MonthFeb) ? civil.month - 4'd3
                                                         : civil.month + 4'd9;
        cy_prod    = {13'b0, civil.year} * {14'b0, nyutc_pkg::Div100Mul};
        s1_next.cy = cy_prod[nyutc_pkg::Div100Shift +: 8];
        s1_next.ok = (civil.year >= nyutc_pkg::YearMin) && (civil.year <= nyutc_pkg::YearMax)
                  && (civil.month >= nyutc_pkg::MonthJan)
                  && (civil.month <= nyutc_pkg::MonthDec)
                  && (civil.day != 5'd0) && (civil.hour <= nyutc_pkg::HourMax)
                  && (civil.minute <= nyutc_pkg::MinuteMax)
                  && (civil.second <= nyutc_pkg::SecondMax);
    end

    // stage 2
    logic [26:0] c_prod;
    logic [13:0] cy_x100;
    logic        leap;
    always_comb
    begin
        c_prod  = {13'b0, s1_reg.yy} * {14'b0, nyutc_pkg::Div100Mul};
        cy_x100 = {6'b0, s1_reg.cy} * 14'd100;
        // divisible by 4, and not a century unless the century is divisible by 4
        leap    = (s1_reg.year[1:0] == 2'b00)
               && ((s1_reg.year != cy_x100) || (s1_reg.cy[1:0] == 2'b00));
        s2_next.yy    = s1_reg.yy;
        s2_next.c     = c_prod[nyutc_pkg::Div100Shift +: 8];
        s2_next.mp    = s1_reg.mp;
        s2_next.month = s1_reg.month;
        s2_next.day   = s1_reg.day;
        s2_next.hour  = s1_reg.hour;
        s2_next.hms   = {12'b0, s1_reg.hour} * 17'd3600 + {11'b0, s1_reg.minute} * 17'd60
                      + {11'b0, s1_reg.second};
        s2_next.ok    = s1_reg.ok
                     && (s1_reg.day <= nyutc_pkg::month_len(s1_reg.month, leap));
    end

    // stage 3
    logic [23:0] nsum;
    always_comb
    begin
        nsum = {10'b0, s2_reg.yy} * 24'd365 + {12'b0, s2_reg.yy[13:2]}
             - {16'b0, s2_reg.c} + {18'b0, s2_reg.c[7:2]}
             + {15'b0, nyutc_pkg::march_offset(s2_reg.mp)};
        s3_next.nbase = nsum[21:0];
        s3_next.month = s2_reg.month;
        s3_next.day   = s2_reg.day;
        s3_next.hour  = s2_reg.hour;
        s3_next.hms   = s2_reg.hms;
        s3_next.ok    = s2_reg.ok;
    end

    // stage 4
    always_comb
    begin
        s4_next.wday  = nyutc_pkg::mod7(s3_reg.nbase + nyutc_pkg::WeekdayBias);
        s4_next.n     = s3_reg.nbase + {17'b0, s3_reg.day} - 22'd1;
        s4_next.month = s3_reg.month;
        s4_next.day   = s3_reg.day;
        s4_next.hour  = s3_reg.hour;
        s4_next.hms   = s3_reg.hms;
        s4_next.ok    = s3_reg.ok;
    end

    // stage 5
    logic [4:0] first_sun;
    logic [4:0] trans_day;
    logic       is_mar;
    logic       is_nov;
    logic       gap;
    logic       dst;
    always_comb
    begin
        first_sun = (s4_reg.wday == 3'd0) ? 5'd1 : 5'd8 - {2'b0, s4_reg.wday};
        is_mar    = (s4_reg.month == nyutc_pkg::MonthMar);
        is_nov    = (s4_reg.month == nyutc_pkg::MonthNov);
        // march switches on the second sunday, november on the first
        trans_day = is_mar ? first_sun + 5'd7 : first_sun;
        gap = 1'b0;
        if (is_mar)
        begin
            gap = (s4_reg.day == trans_day) && (s4_reg.hour == nyutc_pkg::HourGap);
            dst = (s4_reg.day > trans_day)
               || ((s4_reg.day == trans_day) && (s4_reg.hour >= nyutc_pkg::HourDstOn));
        end
        else if (is_nov)
        begin
            gap = (s4_reg.day == trans_day) && (s4_reg.hour == nyutc_pkg::HourRepeat);
            dst = (s4_reg.day < trans_day)
               || ((s4_reg.day == trans_day) && (s4_reg.hour < nyutc_pkg::HourRepeat));
        end
        else
        begin
            dst = (s4_reg.month > nyutc_pkg::MonthMar) && (s4_reg.month < nyutc_pkg::MonthNov);
        end
        if (!s4_reg.ok)
            s5_next.status = nyutc_pkg::StatusRange;
        else if (gap)
            s5_next.status = nyutc_pkg::StatusDst;
        else
            s5_next.status = nyutc_pkg::StatusOk;
        s5_next.days = $signed({1'b0, s4_reg.n}) - nyutc_pkg::EpochDay;
        s5_next.sod  = s4_reg.hms + (dst ? nyutc_pkg::DstOffset : nyutc_pkg::StdOffset);
    end

    // stage 6
    logic signed [40:0] day_prod;
    always_comb
    begin
        day_prod       = s5_reg.days * $signed({1'b0, nyutc_pkg::SecPerDay});
        s6_next.prod   = day_prod[38:0];
        s6_next.sod    = s5_reg.sod;
        s6_next.status = s5_reg.status;
    end

    // stage 7
    always_comb
    begin
        s7_next.status = s6_reg.status;
        s7_next.utc    = (s6_reg.status == nyutc_pkg::StatusOk)
                       ? $signed(s6_reg.prod + {22'b0, s6_reg.sod}) : 39'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0]) s1_reg <= s1_next;
        if (adv[1]) s2_reg <= s2_next;
        if (adv[2]) s3_reg <= s3_next;
        if (adv[3]) s4_reg <= s4_next;
        if (adv[4]) s5_reg <= s5_next;
        if (adv[5]) s6_reg <= s6_next;
        if (adv[6]) s7_reg <= s7_next;
    end

endmodule
`default_nettype wire

[hdl/nyutc_checker.sv]
`default_nettype none
module nyutc_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic [nyutc_pkg::StatusW-1:0]      status,
    input wire logic signed [nyutc_pkg::UtcW-1:0]  utc_seconds
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(utc_seconds))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == nyutc_pkg::StatusOk) || (status == nyutc_pkg::StatusRange)
                   || (status == nyutc_pkg::StatusDst))
        else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != nyutc_pkg::StatusOk) |-> (utc_seconds == '0))
        else $error("rejected item carries nonzero seconds");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == nyutc_pkg::StatusOk)
            |-> (utc_seconds >= nyutc_pkg::UtcMin) && (utc_seconds <= nyutc_pkg::UtcMax))
        else $error("seconds outside the span of years 1900 to 9999");

    // an empty output stage means the whole pipe can move
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

endmodule

bind new_york_civil_time_to_utc nyutc_checker u_nyutc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (civil.ready),
    .out_valid   (utc.valid),
    .out_ready   (utc.ready),
    .status      (utc.status),
    .utc_seconds (utc.utc_seconds)
);
`default_nettype wire
